// ===== rtl/rgb_hsv_pkg.sv =====
// Package: constants and payload types for the RGB to HSV/HSL converter.
package rgb_hsv_pkg;
  localparam int CHANNEL_BITS_DEF  = 12;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int FIELD_IN_BITS     = 12;
  localparam int FIELD_OUT_BITS    = 16;

  typedef struct packed {
    logic [FIELD_IN_BITS-1:0] red;
    logic [FIELD_IN_BITS-1:0] green;
    logic [FIELD_IN_BITS-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [FIELD_OUT_BITS-1:0] hue;
    logic [FIELD_OUT_BITS-1:0] sat_hsv;
    logic [FIELD_OUT_BITS-1:0] value_out;
    logic [FIELD_OUT_BITS-1:0] sat_hsl;
    logic [FIELD_OUT_BITS-1:0] lightness;
  } pix_out_t;
endpackage

// ===== rtl/rgb_hsv_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
module rgb_hsv_div #(
  parameter int NUM_BITS = 32,
  parameter int DEN_BITS = 16,
  parameter int Q_BITS   = 16,
  parameter int TAG_BITS = 1
) (
  input  logic                clk,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  input  logic [TAG_BITS-1:0] tag_in,
  output logic [Q_BITS-1:0]   quo,
  output logic [TAG_BITS-1:0] tag_out
);
  // Quotient is assumed to fit in Q_BITS; remainder kept below den.
  localparam int RW = DEN_BITS + 1;

  logic [RW-1:0]       rem_r [Q_BITS];
  logic [NUM_BITS-1:0] num_r [Q_BITS];
  logic [DEN_BITS-1:0] den_r [Q_BITS];
  logic [Q_BITS-1:0]   q_r   [Q_BITS];
  logic [TAG_BITS-1:0] tag_r [Q_BITS];

  for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
    localparam int BI = Q_BITS - 1 - i;
    logic [RW-1:0]       rem_in;
    logic [NUM_BITS-1:0] num_in;
    logic [DEN_BITS-1:0] den_in;
    logic [Q_BITS-1:0]   q_in;
    logic [TAG_BITS-1:0] tag_s;
    logic [RW:0]         trial_nxt;
    logic [RW-1:0]       rem_nxt;
    logic                bit_nxt;
    if (i == 0) begin : g_first
      // Upper numerator bits above the quotient window form the first remainder.
      assign rem_in = RW'(num >> Q_BITS);
      assign num_in = num;
      assign den_in = den;
      assign q_in   = '0;
      assign tag_s  = tag_in;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign num_in = num_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
      assign tag_s  = tag_r[i-1];
    end
    always_comb begin
      trial_nxt = {rem_in, num_in[BI]};
      bit_nxt = trial_nxt >= (RW+1)'(den_in);
      rem_nxt = bit_nxt ? RW'(trial_nxt - (RW+1)'(den_in)) : RW'(trial_nxt);
    end
    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      num_r[i] <= num_in;
      den_r[i] <= den_in;
      q_r[i]   <= q_in | (Q_BITS'(bit_nxt) << BI);
      tag_r[i] <= tag_s;
    end
  end

  assign quo     = q_r[Q_BITS-1];
  assign tag_out = tag_r[Q_BITS-1];
endmodule

// ===== rtl/rgb_to_hsv_hsl_top.sv =====
// RGB to HSV/HSL converter: max/min stage, numerator stages, dividers, reciprocal scaling.
// Three entry stages, FRACTION_BITS + 1 divider stages and the output register lie
// between the start beat and the result edge.
// Throughput: one pixel per cycle; busy is always low, so start may stay high.
// Synchronous active-low reset clears valid bits only; payload is not reset.
// The receiver cannot stall; each result shows for one cycle under out_valid.
module rgb_to_hsv_hsl_top
  import rgb_hsv_pkg::*;
#(
  parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pix_in_t  in_pix,
  output logic     out_valid,
  output pix_out_t out_pix
);
  localparam int CB = CHANNEL_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int QB = FB + 1;            // quotients reach FMAX (and 2^F for hue guard)
  localparam int DB = CB + 3;            // 6c fits in CB+3 bits
  localparam int NB = DB + FB + 1;
  localparam int LAT = QB + 4;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};
  localparam logic [FB-1:0] FMAX = {FB{1'b1}};
  // floor(y * FMAX / CMAX) = (y * RECIP) >> RK, exact for y <= 2 * CMAX
  localparam int RK = 2 * CB + 1;
  localparam int MB = FB + CB + 2;
  localparam int PB = CB + 1 + MB;
  localparam logic [63:0] RECIP_W = ((64'(FMAX) << RK) + 64'(CMAX) - 64'd1) / 64'(CMAX);
  localparam logic [MB-1:0] RECIP = RECIP_W[MB-1:0];

  assign busy = 1'b0;

  // stage 1: extract channels, max, min
  logic [CB-1:0] r1_r, g1_r, b1_r, mx1_r, mn1_r;
  logic [CB-1:0] r_i, g_i, b_i, mx_i, mn_i;
  always_comb begin
    r_i = CB'(in_pix.red);
    g_i = CB'(in_pix.green);
    b_i = CB'(in_pix.blue);
    mx_i = r_i; mn_i = r_i;
    if (g_i > mx_i) mx_i = g_i;
    if (b_i > mx_i) mx_i = b_i;
    if (g_i < mn_i) mn_i = g_i;
    if (b_i < mn_i) mn_i = b_i;
  end
  always_ff @(posedge clk) begin
    r1_r <= r_i; g1_r <= g_i; b1_r <= b_i; mx1_r <= mx_i; mn1_r <= mn_i;
  end

  // stage 2: chroma, sum, hue numerator, divisors
  logic [CB-1:0] c2_r, mx2_r;
  logic [CB:0]   sum2_r, sden2_r;
  logic [DB-1:0] hnum2_r, six2_r;
  logic          hz2_r, sz2_r, lz2_r;
  logic [CB-1:0] c_s;
  logic [CB:0]   sum_s;
  logic [DB-1:0] six_s, hn_s;
  always_comb begin
    c_s   = mx1_r - mn1_r;
    sum_s = {1'b0, mx1_r} + {1'b0, mn1_r};
    six_s = DB'(c_s) * DB'(6);
    if (g1_r == mx1_r)
      hn_s = DB'(b1_r) + (DB'(c_s) << 1) - DB'(r1_r);
    else if (b1_r == mx1_r)
      hn_s = (DB'(c_s) << 2) + DB'(r1_r) - DB'(g1_r);
    else if (g1_r >= b1_r)
      hn_s = DB'(g1_r) - DB'(b1_r);
    else
      hn_s = six_s - (DB'(b1_r) - DB'(g1_r));
  end
  always_ff @(posedge clk) begin
    c2_r    <= c_s;
    mx2_r   <= mx1_r;
    sum2_r  <= sum_s;
    sden2_r <= (sum_s <= (CB+1)'(CMAX)) ? sum_s : ({CMAX, 1'b0} - sum_s);
    hnum2_r <= hn_s;
    six2_r  <= six_s;
    hz2_r   <= (c_s == '0);
    sz2_r   <= (mx1_r == '0);
    lz2_r   <= (mx1_r == '0) || (mn1_r == CMAX);
  end

  // stage 3: products by FMAX, 2^F and RECIP; zero-guarded divisors
  logic [NB-1:0] hn3_r, sv3_r, sl3_r;
  logic [PB-1:0] vp3_r, lp3_r;
  logic [DB-1:0] hd3_r;
  logic [CB-1:0] svd3_r;
  logic [CB:0]   sld3_r;
  logic [2:0]    zf3_r;
  always_ff @(posedge clk) begin
    hn3_r  <= NB'(hnum2_r) << FB;
    sv3_r  <= NB'(c2_r) * NB'(FMAX);
    sl3_r  <= NB'(c2_r) * NB'(FMAX);
    vp3_r  <= PB'(mx2_r) * PB'(RECIP);
    lp3_r  <= PB'(sum2_r) * PB'(RECIP);
    hd3_r  <= hz2_r ? DB'(1) : six2_r;
    svd3_r <= sz2_r ? CB'(1) : mx2_r;
    sld3_r <= lz2_r ? (CB+1)'(1) : sden2_r;
    zf3_r  <= {hz2_r, sz2_r, lz2_r};
  end

  // value and lightness ride alongside the dividers; lightness halves the scaled sum
  logic [FB-1:0] vd_r [QB];
  logic [FB-1:0] ld_r [QB];
  always_ff @(posedge clk) begin
    vd_r[0] <= vp3_r[RK +: FB];
    ld_r[0] <= lp3_r[RK+1 +: FB];
    for (int j = 1; j < QB; j++) begin
      vd_r[j] <= vd_r[j-1];
      ld_r[j] <= ld_r[j-1];
    end
  end

  logic [QB-1:0] hq, svq, slq;
  logic [2:0]    zf_o, unused_a, unused_c;
  rgb_hsv_div #(.NUM_BITS(NB), .DEN_BITS(DB), .Q_BITS(QB), .TAG_BITS(3)) u_hue (
    .clk, .num(hn3_r), .den(hd3_r), .tag_in(zf3_r), .quo(hq), .tag_out(zf_o));
  rgb_hsv_div #(.NUM_BITS(NB), .DEN_BITS(CB), .Q_BITS(QB), .TAG_BITS(3)) u_shsv (
    .clk, .num(sv3_r), .den(svd3_r), .tag_in(zf3_r), .quo(svq), .tag_out(unused_a));
  rgb_hsv_div #(.NUM_BITS(NB), .DEN_BITS(CB+1), .Q_BITS(QB), .TAG_BITS(3)) u_shsl (
    .clk, .num(sl3_r), .den(sld3_r), .tag_in(zf3_r), .quo(slq), .tag_out(unused_c));

  logic          unused_ok;
  assign unused_ok = ^{unused_a, unused_c};

  logic [LAT-1:0] vld_r;
  pix_out_t       out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], start & ~busy};
    out_r.hue       <= zf_o[2] ? '0 : FIELD_OUT_BITS'(hq);
    out_r.sat_hsv   <= zf_o[1] ? '0 : FIELD_OUT_BITS'(svq);
    out_r.value_out <= FIELD_OUT_BITS'(vd_r[QB-1]);
    out_r.sat_hsl   <= (zf_o[0] || unused_ok & 1'b0) ? '0 : FIELD_OUT_BITS'(slq);
    out_r.lightness <= FIELD_OUT_BITS'(ld_r[QB-1]);
  end
  assign out_valid = vld_r[LAT-1];
  assign out_pix   = out_r;

  a_busy_low: assert property (@(posedge clk) busy == 1'b0) else $error("busy high");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT)) else $error("result without start");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##1 vld_r[0]) else $error("start lost");
endmodule
